// ----- rtl/lpnt_pkg.sv -----
// Package for the loop pattern note trigger.
// Holds state, op and register codes and shared constants; no dependencies.
package lpnt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN
    } t_state;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_LOOP_LENGTH = 2'd0,
        REG_NOTE_COUNT  = 2'd1,
        REG_ENABLED     = 2'd2,
        REG_MASTER_GAIN = 2'd3
    } t_reg;

    localparam logic [15:0] EMPTY_ID    = 16'hFFFF;
    localparam logic [15:0] GAIN_MAX    = 16'd32768;
    localparam logic [15:0] GAIN_RESET  = 16'd16384;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ratio;
        logic [15:0] pitch;
        logic [15:0] velocity;
        logic [15:0] sample_id;
        logic [31:0] start;
    } t_note;

endpackage

// ----- rtl/loop_pattern_note_trigger.sv -----
// Loop pattern note trigger: top level; depends on lpnt_pkg.
// Tick: busy stays high through restoring division, then through the scan of the
// note memory (one entry a cycle) and its drain; the last beat shows in the same
// cycle that busy falls, and a new tick is taken only once busy is low again.
// Writes, clears and ticks with no division keep busy low; receiver cannot stall.
// Reset is synchronous active low; marks read as never triggered after reset.
module loop_pattern_note_trigger #(
    parameter int MAX_NOTES     = 32,
    parameter int POSITION_BITS = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_op,
    input  logic [POSITION_BITS-1:0] i_position,
    input  logic                     i_playing,
    input  logic [4:0]               i_note_index,
    input  logic [31:0]              i_note_start,
    input  logic [15:0]              i_sample_id,
    input  logic [15:0]              i_velocity,
    input  logic signed [15:0]       i_pitch,
    input  logic [15:0]              i_time_ratio,
    input  logic [1:0]               i_mode,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [31:0]              i_cfg_data,
    output logic                     o_valid,
    output logic [4:0]               o_fired_index,
    output logic [15:0]              o_out_sample_id,
    output logic [15:0]              o_out_velocity,
    output logic [15:0]              o_out_gain,
    output logic signed [15:0]       o_out_pitch,
    output logic [15:0]              o_out_ratio,
    output logic [1:0]               o_out_mode,
    output logic                     o_last
);
    import lpnt_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int DW = $clog2(POSITION_BITS + 1);

    t_state r_state, n_state;

    logic [31:0] r_len;
    logic [5:0]  r_ncount;
    logic        r_enabled;
    logic [15:0] r_gain;

    t_note       r_note_mem [MAX_NOTES];
    logic [PB-1:0] r_mark_mem [MAX_NOTES];
    logic [MAX_NOTES-1:0] r_mark_vld;

    t_note         r_note_q;
    logic [PB-1:0] r_mark_q;
    logic          r_mvld_q;

    logic [32:0]   r_rem, n_rem;
    logic [PB-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dcnt, n_dcnt;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_ridx, n_ridx;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_hold_v, n_hold_v;
    logic [4:0]    r_hold_idx, n_hold_idx;
    t_note         r_hold, n_hold;

    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;
    logic [4:0]    r_oidx, n_oidx;
    t_note         r_onote, n_onote;
    logic [15:0]   r_ogain;

    logic          w_accept;
    logic [32:0]   w_sh, w_sub;
    logic          w_ge;
    logic [PB-1:0] w_mark;
    logic          w_hit;
    logic          w_rd;
    logic          w_scan_end;
    logic [CW-1:0] w_cnt;

    assign w_accept   = start && !busy;
    assign w_sh       = {r_rem[31:0], r_quo[PB-1]};
    assign w_sub      = w_sh - {1'b0, r_len};
    assign w_ge       = w_sh >= {1'b0, r_len};
    assign w_mark     = r_mvld_q ? r_mark_q : {PB{1'b1}};
    assign w_hit      = r_pv && (r_note_q.sample_id != EMPTY_ID)
                        && (r_note_q.start == r_rem[31:0]) && (w_mark != r_quo);
    assign w_rd       = (r_state == ST_SCAN) && (r_ridx < r_cnt);
    assign w_scan_end = (r_state == ST_SCAN) && !w_rd && !r_pv;
    assign w_cnt      = ({1'b0, r_ncount} > 7'(MAX_NOTES)) ? CW'(MAX_NOTES) : CW'(r_ncount);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_op == OP_TICK) && i_playing && r_enabled
                    && (r_ncount != 6'd0) && (r_len != 32'd0)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == DW'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dcnt     = r_dcnt;
        n_cnt      = r_cnt;
        n_ridx     = r_ridx;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_hold_v   = r_hold_v;
        n_hold_idx = r_hold_idx;
        n_hold     = r_hold;
        n_ovalid   = 1'b0;
        n_olast    = 1'b0;
        n_oidx     = r_oidx;
        n_onote    = r_onote;
        case (r_state)
            ST_IDLE: begin
                n_rem    = '0;
                n_quo    = i_position;
                n_dcnt   = DW'(PB);
                n_cnt    = w_cnt;
                n_ridx   = '0;
                n_hold_v = 1'b0;
            end
            ST_DIV: begin
                n_rem  = w_ge ? w_sub : w_sh;
                n_quo  = {r_quo[PB-2:0], w_ge};
                n_dcnt = r_dcnt - DW'(1);
            end
            ST_SCAN: begin
                if (w_rd) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[IW-1:0];
                    n_ridx = r_ridx + CW'(1);
                end
                if (w_hit) begin
                    n_hold_v   = 1'b1;
                    n_hold_idx = 5'(r_pidx);
                    n_hold     = r_note_q;
                    if (r_hold_v) begin
                        n_ovalid = 1'b1;
                        n_oidx   = r_hold_idx;
                        n_onote  = r_hold;
                    end
                end
                if (w_scan_end && r_hold_v) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    n_oidx   = r_hold_idx;
                    n_onote  = r_hold;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_ncount   <= '0;
            r_enabled  <= 1'b1;
            r_gain     <= GAIN_RESET;
            r_mark_vld <= '0;
            r_pv       <= 1'b0;
            r_hold_v   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_hold_v <= n_hold_v;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOOP_LENGTH: r_len     <= i_cfg_data;
                    REG_NOTE_COUNT:  r_ncount  <= i_cfg_data[5:0];
                    REG_ENABLED:     r_enabled <= i_cfg_data[0];
                    REG_MASTER_GAIN: begin
                        r_gain <= (i_cfg_data[15:0] > GAIN_MAX) ? GAIN_MAX
                                                                 : i_cfg_data[15:0];
                    end
                    default: ;
                endcase
            end
            if (w_accept && (i_op == OP_CLEAR)) begin
                r_mark_vld <= '0;
            end
            if (w_hit) begin
                r_mark_vld[r_pidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dcnt     <= n_dcnt;
        r_cnt      <= n_cnt;
        r_ridx     <= n_ridx;
        r_pidx     <= n_pidx;
        r_hold_idx <= n_hold_idx;
        r_hold     <= n_hold;
        r_olast    <= n_olast;
        r_oidx     <= n_oidx;
        r_onote    <= n_onote;
        r_ogain    <= r_gain;
    end

    // note and mark memories
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op == OP_WRITE) && (i_note_index < MAX_NOTES)) begin
            r_note_mem[IW'(i_note_index)] <= '{mode: i_mode, ratio: i_time_ratio,
                                               pitch: i_pitch, velocity: i_velocity,
                                               sample_id: i_sample_id,
                                               start: i_note_start};
        end
        if (w_rd) begin
            r_note_q <= r_note_mem[r_ridx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_mark_mem[r_pidx] <= r_quo;
        end
        if (w_rd) begin
            r_mark_q <= r_mark_mem[r_ridx[IW-1:0]];
            r_mvld_q <= r_mark_vld[r_ridx[IW-1:0]];
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_last          = r_olast;
    assign o_fired_index   = r_oidx;
    assign o_out_sample_id = r_onote.sample_id;
    assign o_out_velocity  = r_onote.velocity;
    assign o_out_gain      = r_ogain;
    assign o_out_pitch     = r_onote.pitch;
    assign o_out_ratio     = r_onote.ratio;
    assign o_out_mode      = r_onote.mode;

endmodule

// ----- rtl/lpnt_checker.sv -----
// Port-level checker for the loop pattern note trigger, bound to the top level.
// Depends on loop_pattern_note_trigger.
module lpnt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic        o_last,
    input logic [15:0] o_out_sample_id
);

    a_valid_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat outside a tick");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("busy or result after reset");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat after last beat");

    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_sample_id != 16'hFFFF))
        else $error("empty note fired");

endmodule

bind loop_pattern_note_trigger lpnt_checker u_lpnt_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .busy(busy),
    .o_valid(o_valid),
    .o_last(o_last),
    .o_out_sample_id(o_out_sample_id)
);
